// ===== sv/first_unique_symbol_per_word_defines.svh =====
// Assertion macros for the first_unique_symbol_per_word RTL.
// Requires clk and rst_n in the scope of every use.
`ifndef FIRST_UNIQUE_SYMBOL_PER_WORD_DEFINES_SVH
`define FIRST_UNIQUE_SYMBOL_PER_WORD_DEFINES_SVH

`ifndef SYNTHESIS
`define FUSW_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fusw: implication check failed");
`define FUSW_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fusw: next-cycle check failed");
`else
`define FUSW_ASSERT_IMP(label, ante, cons)
`define FUSW_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ===== sv/fusw_pkg.sv =====
// Shared types, constants and helpers for first_unique_symbol_per_word.
// No dependencies.
package fusw_pkg;

  localparam int SYMBOL_BITS_DEF = 8;
  localparam int CELLS_DEF       = 256;

  localparam logic [7:0] BLANK = 8'h20;

  localparam logic KIND_WORD = 1'b0;
  localparam logic KIND_TEXT = 1'b1;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_text;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] unique_symbol;
    logic       found;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic ins_v;
    logic srch;
    logic hit_v;
    logic res_v;
    logic res_found;
    logic fin;
  } tok_ctl_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

endpackage

// ===== sv/fusw_cell.sv =====
// One cell of a symbol chain: holds one symbol slot in order of first sight.
// Depends on fusw_pkg.
module fusw_cell #(
  parameter int KEY_BITS = fusw_pkg::SYMBOL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  fusw_pkg::tok_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]  ins_key_i,
  input  logic [KEY_BITS-1:0]  hit_key_i,
  input  logic [7:0]           res_sym_i,
  output fusw_pkg::tok_ctl_t   ctl_o,
  output logic [KEY_BITS-1:0]  ins_key_o,
  output logic [KEY_BITS-1:0]  hit_key_o,
  output logic [7:0]           res_sym_o
);
  import fusw_pkg::*;

  logic                valid_r, valid_nxt;
  logic                multi_r, multi_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  tok_ctl_t            ctl_r, ctl_nxt;
  logic [KEY_BITS-1:0] ins_key_r;
  logic [KEY_BITS-1:0] hit_key_r, hit_key_nxt;
  logic [7:0]          res_sym_r;
  logic                match, take, hit;
  logic                eff_valid, eff_multi;
  logic [KEY_BITS-1:0] eff_key;

  always_comb begin
    match     = ctl_i.ins_v && valid_r && (key_r == ins_key_i);
    take      = ctl_i.ins_v && !valid_r;
    eff_valid = valid_r || take;
    eff_key   = take ? ins_key_i : key_r;
    eff_multi = take ? 1'b0 : (multi_r || match);
    hit       = ctl_i.srch && !ctl_i.hit_v && eff_valid && !eff_multi;

    ctl_nxt       = ctl_i;
    ctl_nxt.ins_v = ctl_i.ins_v && !match && !take;
    ctl_nxt.hit_v = ctl_i.hit_v || hit;
    hit_key_nxt   = hit ? eff_key : hit_key_i;

    valid_nxt = ctl_i.srch ? 1'b0 : eff_valid;
    key_nxt   = eff_key;
    multi_nxt = eff_multi;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ctl_r   <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      ctl_r   <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r     <= key_nxt;
      multi_r   <= multi_nxt;
      ins_key_r <= ins_key_i;
      hit_key_r <= hit_key_nxt;
      res_sym_r <= res_sym_i;
    end
  end

  assign ctl_o     = ctl_r;
  assign ins_key_o = ins_key_r;
  assign hit_key_o = hit_key_r;
  assign res_sym_o = res_sym_r;

endmodule

// ===== sv/fusw_chain.sv =====
// Row of fusw_cell instances; tokens step one cell per advancing cycle.
// Depends on fusw_pkg and fusw_cell.
module fusw_chain #(
  parameter int KEY_BITS = fusw_pkg::SYMBOL_BITS_DEF,
  parameter int CELLS    = fusw_pkg::CELLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  fusw_pkg::tok_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]  ins_key_i,
  input  logic [KEY_BITS-1:0]  hit_key_i,
  input  logic [7:0]           res_sym_i,
  output fusw_pkg::tok_ctl_t   ctl_o,
  output logic [KEY_BITS-1:0]  hit_key_o,
  output logic [7:0]           res_sym_o
);
  import fusw_pkg::*;

  tok_ctl_t            ctl_w     [CELLS+1];
  logic [KEY_BITS-1:0] ins_key_w [CELLS+1];
  logic [KEY_BITS-1:0] hit_key_w [CELLS+1];
  logic [7:0]          res_sym_w [CELLS+1];

  assign ctl_w[0]     = ctl_i;
  assign ins_key_w[0] = ins_key_i;
  assign hit_key_w[0] = hit_key_i;
  assign res_sym_w[0] = res_sym_i;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    fusw_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .ctl_i     (ctl_w[i]),
      .ins_key_i (ins_key_w[i]),
      .hit_key_i (hit_key_w[i]),
      .res_sym_i (res_sym_w[i]),
      .ctl_o     (ctl_w[i+1]),
      .ins_key_o (ins_key_w[i+1]),
      .hit_key_o (hit_key_w[i+1]),
      .res_sym_o (res_sym_w[i+1])
    );
  end

  assign ctl_o     = ctl_w[CELLS];
  assign hit_key_o = hit_key_w[CELLS];
  assign res_sym_o = res_sym_w[CELLS];

endmodule

// ===== sv/fusw_out.sv =====
// Result sequencer at the tail of the text chain: zero, one or two beats per token.
// Depends on fusw_pkg and first_unique_symbol_per_word_defines.svh.
`include "first_unique_symbol_per_word_defines.svh"

module fusw_out #(
  parameter int KEY_BITS = fusw_pkg::SYMBOL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fusw_pkg::tok_ctl_t   ctl_i,
  input  logic [KEY_BITS-1:0]  hit_key_i,
  input  logic [7:0]           res_sym_i,
  input  logic                 out_ready,
  output logic                 out_valid,
  output fusw_pkg::out_beat_t  out_payload,
  output logic                 adv
);
  import fusw_pkg::*;

  logic                sent_r;
  logic                word_beat;
  logic [KEY_BITS+7:0] key_wide;
  logic [7:0]          text_sym;

  assign key_wide = {8'h00, hit_key_i};
  assign text_sym = ctl_i.hit_v ? key_wide[7:0] : BLANK;

  always_comb begin
    word_beat = ctl_i.res_v && !sent_r;
    out_valid = word_beat || ctl_i.fin;
    if (word_beat) begin
      out_payload.kind          = KIND_WORD;
      out_payload.unique_symbol = res_sym_i;
      out_payload.found         = ctl_i.res_found;
      out_payload.last          = !ctl_i.fin;
    end else begin
      out_payload.kind          = KIND_TEXT;
      out_payload.unique_symbol = text_sym;
      out_payload.found         = ctl_i.hit_v;
      out_payload.last          = 1'b1;
    end
    adv = !out_valid || (out_ready && out_payload.last);
  end

  // hold the token while its word beat has gone and the text beat waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r <= 1'b0;
    end else if (adv) begin
      sent_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      sent_r <= 1'b1;
    end
  end

  `FUSW_ASSERT_IMP(a_text_is_last, out_valid && out_payload.kind == KIND_TEXT, out_payload.last)
  `FUSW_ASSERT_IMP(a_blank_when_none, out_valid && !out_payload.found, out_payload.unique_symbol == BLANK)
  `FUSW_ASSERT_NXT(a_text_follows_word, out_valid && out_ready && !out_payload.last, out_valid && out_payload.kind == KIND_TEXT)

endmodule

// ===== sv/first_unique_symbol_per_word.sv =====
// Top level: word chain, text chain and result sequencer.
// Depends on fusw_pkg, fusw_chain and fusw_out.
//
//   port group  dir  payload     handshake
//   in_         in   in_beat_t   in_valid / in_ready
//   out_        out  out_beat_t  out_valid / out_ready
//
// One byte a cycle enters the word chain while the tail is not stalled.
// A result beat is offered once its byte has passed every cell of both chains; each cell is one stage.
// A final byte that closes a word gives two beats, which stall the chains until the second is taken.
// Reset clears all cell slots at once; no clearing pass.
// A stalled output beat holds both chains and in_ready.
module first_unique_symbol_per_word #(
  parameter int SYMBOL_BITS = fusw_pkg::SYMBOL_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fusw_pkg::in_beat_t   in_payload,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fusw_pkg::out_beat_t  out_payload
);
  import fusw_pkg::*;

  localparam int CELLS = (SYMBOL_BITS >= 8) ? 256 : (1 << SYMBOL_BITS);

  logic                   adv;
  logic                   acc, space, word_open;
  logic                   inside_r, inside_nxt;
  logic [SYMBOL_BITS+7:0] in_wide, wsym_wide, hit_wide;
  logic [SYMBOL_BITS-1:0] in_key, t_key;
  logic [7:0]             wsym;
  tok_ctl_t               w_head, w_tail, t_head, t_tail;
  logic [SYMBOL_BITS-1:0] w_hit_key, t_hit_key;
  logic [7:0]             w_res_sym, t_res_sym;

  assign in_ready = adv;

  always_comb begin
    acc        = in_valid && adv;
    space      = is_space(in_payload.symbol);
    word_open  = inside_r || !space;
    inside_nxt = word_open && !space && !in_payload.end_of_text;
    in_wide    = {{SYMBOL_BITS{1'b0}}, in_payload.symbol};
    in_key     = in_wide[SYMBOL_BITS-1:0];

    w_head           = '0;
    w_head.ins_v     = acc && !space;
    w_head.srch      = acc && word_open && (space || in_payload.end_of_text);
    w_head.fin       = acc && in_payload.end_of_text;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (acc) begin
      inside_r <= inside_nxt;
    end
  end

  fusw_chain #(
    .KEY_BITS (SYMBOL_BITS),
    .CELLS    (CELLS)
  ) u_word_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_i     (w_head),
    .ins_key_i (in_key),
    .hit_key_i ('0),
    .res_sym_i (8'h00),
    .ctl_o     (w_tail),
    .hit_key_o (w_hit_key),
    .res_sym_o (w_res_sym)
  );

  always_comb begin
    hit_wide  = {8'h00, w_hit_key};
    wsym      = w_tail.hit_v ? hit_wide[7:0] : BLANK;
    wsym_wide = {{SYMBOL_BITS{1'b0}}, wsym};
    t_key     = wsym_wide[SYMBOL_BITS-1:0];

    t_head           = '0;
    t_head.ins_v     = w_tail.srch;
    t_head.res_v     = w_tail.srch;
    t_head.res_found = w_tail.hit_v;
    t_head.srch      = w_tail.fin;
    t_head.fin       = w_tail.fin;
  end

  fusw_chain #(
    .KEY_BITS (SYMBOL_BITS),
    .CELLS    (CELLS)
  ) u_text_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .ctl_i     (t_head),
    .ins_key_i (t_key),
    .hit_key_i ('0),
    .res_sym_i (wsym),
    .ctl_o     (t_tail),
    .hit_key_o (t_hit_key),
    .res_sym_o (t_res_sym)
  );

  fusw_out #(
    .KEY_BITS (SYMBOL_BITS)
  ) u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (t_tail),
    .hit_key_i   (t_hit_key),
    .res_sym_i   (t_res_sym),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_payload (out_payload),
    .adv         (adv)
  );

endmodule
